// ----- hdl/mlft_pkg.sv -----
// mlft_pkg: shared types and codes of the mac learning forward table
// no dependencies; imported by the table top level and its checker

package mlft_pkg;

    typedef logic [47:0] t_mac;
    typedef logic [1:0]  t_mode;
    typedef logic [2:0]  t_verdict;
    typedef logic [3:0]  t_slot4;
    typedef logic [15:0] t_mask16;

    // operation codes carried in the mode field
    localparam t_mode MODE_LOOKUP = 2'd0;
    localparam t_mode MODE_LEARN  = 2'd1;
    localparam t_mode MODE_STATUS = 2'd2;
    localparam t_mode MODE_FORGET = 2'd3;

    // result codes
    localparam t_verdict VERDICT_UNICAST   = 3'd0;
    localparam t_verdict VERDICT_BROADCAST = 3'd1;
    localparam t_verdict VERDICT_LEARNED   = 3'd2;
    localparam t_verdict VERDICT_KNOWN     = 3'd3;
    localparam t_verdict VERDICT_FULL      = 3'd4;
    localparam t_verdict VERDICT_DONE      = 3'd5;

endpackage

// ----- hdl/mlft_ram.sv -----
// mlft_ram: generic simple dual port ram, one write and one registered read
// no dependencies; used for the mac entries and the per peer fill counts

module mlft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mac_learning_forward_table.sv -----
// mac_learning_forward_table: per peer mac learning table with one shared comparator
// depends on mlft_pkg and mlft_ram
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+-------------------------------------------
// input   | in        | i_in_valid / o_in_ready | i_mode i_mac_addr i_peer_slot i_online_flag
// result  | out       | o_out_valid/ i_out_ready| o_verdict o_target_slot o_online_mask
//
// status and forget items go from the accepting state straight to the output stage.
// learn reads the peer's fill count and scans its learned entries for the address.
// lookup steps through the slots, skipping offline ones and scanning the online ones;
// each entry passes the single 48-bit comparator fed by the entry ram's one read port.
// reset clears online flags and per peer fill state at once; no clearing pass.
// a finished item waits in the output register; a stalled output holds the sequencer.

module mac_learning_forward_table #(
    parameter int PEER_SLOTS    = 16,
    parameter int MACS_PER_PEER = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mlft_pkg::t_mode     i_mode,
    input  mlft_pkg::t_mac      i_mac_addr,
    input  mlft_pkg::t_slot4    i_peer_slot,
    input  logic                i_online_flag,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mlft_pkg::t_verdict  o_verdict,
    output mlft_pkg::t_slot4    o_target_slot,
    output mlft_pkg::t_mask16   o_online_mask
);

    import mlft_pkg::*;

    localparam int SW  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int SCW = $clog2(PEER_SLOTS + 1);
    localparam int EW  = $clog2(MACS_PER_PEER + 1);
    localparam int TOT = PEER_SLOTS * MACS_PER_PEER;
    localparam int AW  = (TOT > 1) ? $clog2(TOT) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SLOT  = 3'd1;
    localparam logic [2:0] ST_FWAIT = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // control state
    logic [2:0]            r_state, n_state;
    logic [PEER_SLOTS-1:0] r_online, n_online;
    logic [PEER_SLOTS-1:0] r_fvld, n_fvld;
    logic                  r_out_vld, n_out_vld;
    logic                  r_pend, n_pend;

    // working registers
    t_mode     r_mode, n_mode;
    t_mac      r_mac, n_mac;
    logic [SCW-1:0] r_slot, n_slot;
    logic [AW-1:0]  r_base, n_base;
    logic [EW-1:0]  r_fill, n_fill;
    logic [EW-1:0]  r_ent, n_ent;
    t_verdict  r_verdict, n_verdict;
    t_slot4    r_target, n_target;

    // output register
    t_verdict  r_o_verdict, n_o_verdict;
    t_slot4    r_o_target, n_o_target;
    t_mask16   r_o_mask, n_o_mask;

    // ram ports
    logic           w_mac_we;
    logic [AW-1:0]  w_mac_waddr;
    logic [AW-1:0]  w_mac_raddr;
    t_mac           w_mac_rdata;
    logic           w_fill_we;
    logic [SW-1:0]  w_fill_waddr;
    logic [EW-1:0]  w_fill_wdata;
    logic [SW-1:0]  w_fill_raddr;
    logic [EW-1:0]  w_fill_rdata;

    logic           w_accept;
    logic           w_in_range;
    logic [SW-1:0]  w_slot_idx;
    logic [SW-1:0]  w_cur_idx;
    logic           w_hit;
    logic           w_load;
    t_mask16        w_mask;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = ({3'b000, i_peer_slot} < 7'(PEER_SLOTS));
    assign w_slot_idx = SW'(i_peer_slot);
    assign w_cur_idx  = r_slot[SW-1:0];
    assign w_hit      = r_pend && (w_mac_rdata == r_mac);
    assign w_load     = (r_state == ST_FIN) && (!r_out_vld || i_out_ready);

    // online mask of the first sixteen slots
    generate
        for (genvar k = 0; k < 16; k++) begin : g_mask
            if (k < PEER_SLOTS) begin : g_on
                assign w_mask[k] = r_online[k];
            end else begin : g_off
                assign w_mask[k] = 1'b0;
            end
        end
    endgenerate

    // mac entry store, one row of MACS_PER_PEER entries per peer
    mlft_ram #(
        .WIDTH (48),
        .DEPTH (TOT)
    ) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (w_mac_we),
        .i_waddr (w_mac_waddr),
        .i_wdata (r_mac),
        .i_raddr (w_mac_raddr),
        .o_rdata (w_mac_rdata)
    );

    // per peer fill count, meaningful only where the fill valid bit is set
    mlft_ram #(
        .WIDTH (EW),
        .DEPTH (PEER_SLOTS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_fill_waddr),
        .i_wdata (w_fill_wdata),
        .i_raddr (w_fill_raddr),
        .o_rdata (w_fill_rdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_online    = r_online;
        n_fvld      = r_fvld;
        n_out_vld   = r_out_vld;
        n_pend      = r_pend;
        n_mode      = r_mode;
        n_mac       = r_mac;
        n_slot      = r_slot;
        n_base      = r_base;
        n_fill      = r_fill;
        n_ent       = r_ent;
        n_verdict   = r_verdict;
        n_target    = r_target;
        n_o_verdict = r_o_verdict;
        n_o_target  = r_o_target;
        n_o_mask    = r_o_mask;

        w_mac_we     = 1'b0;
        w_mac_waddr  = r_base + AW'(r_fill);
        w_mac_raddr  = r_base + AW'(r_ent);
        w_fill_we    = 1'b0;
        w_fill_waddr = w_cur_idx;
        w_fill_wdata = r_fill + EW'(1);
        w_fill_raddr = (r_state == ST_IDLE) ? w_slot_idx : w_cur_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode    = i_mode;
                    n_mac     = i_mac_addr;
                    n_verdict = VERDICT_DONE;
                    n_target  = '0;
                    n_state   = ST_FIN;
                    unique case (i_mode)
                        MODE_LOOKUP: begin
                            n_slot  = '0;
                            n_base  = '0;
                            n_state = ST_SLOT;
                        end
                        MODE_LEARN: begin
                            if (w_in_range) begin
                                n_slot  = SCW'(i_peer_slot);
                                n_base  = AW'(i_peer_slot) * AW'(MACS_PER_PEER);
                                n_state = ST_FWAIT;
                            end else begin
                                n_verdict = VERDICT_FULL;
                            end
                        end
                        MODE_STATUS: begin
                            if (w_in_range) begin
                                n_online[w_slot_idx] = i_online_flag;
                            end
                        end
                        MODE_FORGET: begin
                            if (w_in_range) begin
                                n_online[w_slot_idx] = 1'b0;
                                n_fvld[w_slot_idx]   = 1'b0;
                            end
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end

            // lookup: pick the next slot, skip offline peers, broadcast after the last slot
            ST_SLOT: begin
                if (r_slot == SCW'(PEER_SLOTS)) begin
                    n_verdict = VERDICT_BROADCAST;
                    n_state   = ST_FIN;
                end else if (!r_online[w_cur_idx]) begin
                    n_slot = r_slot + SCW'(1);
                    n_base = r_base + AW'(MACS_PER_PEER);
                end else begin
                    n_state = ST_FWAIT;
                end
            end

            // fill count arrives from the ram
            ST_FWAIT: begin
                n_fill  = r_fvld[w_cur_idx] ? w_fill_rdata : '0;
                n_ent   = '0;
                n_pend  = 1'b0;
                n_state = ST_SCAN;
            end

            // stream entries through the comparator, one read per cycle; a learn miss writes the entry
            ST_SCAN: begin
                if (r_ent < r_fill) begin
                    n_ent  = r_ent + EW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (w_hit) begin
                    if (r_mode == MODE_LOOKUP) begin
                        n_verdict = VERDICT_UNICAST;
                        n_target  = 4'(r_slot);
                    end else begin
                        n_verdict = VERDICT_KNOWN;
                    end
                    n_state = ST_FIN;
                end else if (r_ent == r_fill) begin
                    if (r_mode == MODE_LOOKUP) begin
                        n_slot  = r_slot + SCW'(1);
                        n_base  = r_base + AW'(MACS_PER_PEER);
                        n_state = ST_SLOT;
                    end else begin
                        if (r_fill == EW'(MACS_PER_PEER)) begin
                            n_verdict = VERDICT_FULL;
                        end else begin
                            w_mac_we          = 1'b1;
                            w_fill_we         = 1'b1;
                            n_fvld[w_cur_idx] = 1'b1;
                            n_verdict         = VERDICT_LEARNED;
                        end
                        n_state = ST_FIN;
                    end
                end
            end

            // hand the result to the output register
            ST_FIN: begin
                if (w_load) begin
                    n_o_verdict = r_verdict;
                    n_o_target  = r_target;
                    n_o_mask    = w_mask;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output valid
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_online  <= '0;
            r_fvld    <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_online  <= n_online;
            r_fvld    <= n_fvld;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_mac       <= n_mac;
        r_slot      <= n_slot;
        r_base      <= n_base;
        r_fill      <= n_fill;
        r_ent       <= n_ent;
        r_verdict   <= n_verdict;
        r_target    <= n_target;
        r_o_verdict <= n_o_verdict;
        r_o_target  <= n_o_target;
        r_o_mask    <= n_o_mask;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_verdict     = r_o_verdict;
    assign o_target_slot = r_o_target;
    assign o_online_mask = r_o_mask;

endmodule

// ----- hdl/mlft_checker.sv -----
// mlft_checker: port level checks of the mac learning forward table
// depends on mlft_pkg; bound to mac_learning_forward_table below

module mlft_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mlft_pkg::t_verdict o_verdict,
    input mlft_pkg::t_slot4   o_target_slot,
    input mlft_pkg::t_mask16  o_online_mask
);

    import mlft_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict)
            && $stable(o_target_slot) && $stable(o_online_mask))
        else $error("result changed while stalled");

    // only unicast names a target
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict != VERDICT_UNICAST) |-> (o_target_slot == 4'd0))
        else $error("target slot set on a non unicast result");

    // one item at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("took a second item without finishing the first");

    // a new result only appears after the block was busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && $past(i_rst_n) |-> $past(!o_in_ready))
        else $error("result appeared without work");

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (.*);
